// ===== design/egsa_pkg.sv =====
package egsa_pkg;

	localparam int FP_W = 32;
	localparam int FIELD_LANES = 4;
	localparam int CFG_AW = 4;

	typedef enum logic {
		OP_ACC  = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CFG_VOCAB   = 2'd0,
		CFG_CHUNKS  = 2'd1,
		CFG_PADDING = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_RD,
		ST_EXE,
		ST_WR
	} state_t;

	localparam logic [FP_W-1:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
	localparam logic [FP_W-1:0] FP_QUIET_BIT   = 32'h0040_0000;

endpackage

// ===== design/embedding_grad_scatter_add_core.sv =====
// Channel   | Direction | Handshake              | Word
// ----------+-----------+------------------------+------------------------------------------
// config    | in        | psel/penable/pwrite    | paddr, pwdata, prdata (APB, pready high)
// items     | in        | in_valid / in_stall    | operation, token, chunk_index, grad_lane_*
// results   | out       | out_valid / out_stall  | sum_lane_*, row_valid
//
// One word at a time. An accumulate into a live row goes through accept, memory read,
// lane adders and write back; a live read through accept, memory read and result load;
// a dropped word ends at accept. After reset, with in_stall high, a clearing pass zeroes
// all MAX_VOCAB*MAX_CHUNKS rows, one row per cycle; config writes are taken meanwhile.
// A read word is held off while a result still waits at the output register.
module embedding_grad_scatter_add_core #(
	parameter int MAX_VOCAB  = 1024,
	parameter int MAX_CHUNKS = 16,
	parameter int LANES      = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [egsa_pkg::CFG_AW-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         operation,
	input  logic [15:0]                  token,
	input  logic [3:0]                   chunk_index,
	input  logic [31:0]                  grad_lane_0,
	input  logic [31:0]                  grad_lane_1,
	input  logic [31:0]                  grad_lane_2,
	input  logic [31:0]                  grad_lane_3,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [31:0]                  sum_lane_0,
	output logic [31:0]                  sum_lane_1,
	output logic [31:0]                  sum_lane_2,
	output logic [31:0]                  sum_lane_3,
	output logic                         row_valid
);
	import egsa_pkg::*;

	localparam int ACT_LANES = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;
	localparam int ROWS = MAX_VOCAB * MAX_CHUNKS;
	localparam int AW = $clog2(ROWS);
	localparam int VW = $clog2(MAX_VOCAB);
	localparam int RW = ACT_LANES * FP_W;

	// configuration registers
	logic [10:0] vocab_q;
	logic [4:0]  chunks_q;
	logic [10:0] pad_q;
	logic        cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vocab_q <= 11'd1024;
			chunks_q <= 5'd16;
			pad_q <= 11'h7FF;
		end else if (cfg_we) begin
			case (paddr[3:2])
				CFG_VOCAB:   vocab_q <= pwdata[10:0];
				CFG_CHUNKS:  chunks_q <= pwdata[4:0];
				CFG_PADDING: pad_q <= pwdata[10:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			CFG_VOCAB:   prdata = {21'd0, vocab_q};
			CFG_CHUNKS:  prdata = {27'd0, chunks_q};
			CFG_PADDING: prdata = {{21{pad_q[10]}}, pad_q};
			default:     prdata = '0;
		endcase
	end

	// decode of the incoming word
	logic [FP_W-1:0] grad_in [FIELD_LANES];
	logic            exists, pad_hit, accept;
	logic [AW-1:0]   addr_in;

	assign grad_in[0] = grad_lane_0;
	assign grad_in[1] = grad_lane_1;
	assign grad_in[2] = grad_lane_2;
	assign grad_in[3] = grad_lane_3;

	always_comb begin
		exists = ({1'b0, token} < 17'(MAX_VOCAB)) && (token < {5'd0, vocab_q})
			&& ({5'd0, chunk_index} < 9'(MAX_CHUNKS)) && ({1'b0, chunk_index} < chunks_q);
		pad_hit = !pad_q[10] && (token == {5'd0, pad_q});
		addr_in = AW'(token[VW-1:0]) * AW'(MAX_CHUNKS) + AW'(chunk_index);
	end

	state_t        state_q, state_d;
	logic [AW-1:0] clr_q, addr_q;
	op_t           op_q;
	logic [FP_W-1:0] grad_q [ACT_LANES];
	logic          out_valid_q, row_valid_q;
	logic [FP_W-1:0] sum_q [FIELD_LANES];

	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && operation == OP_READ);
	assign accept = in_valid && !in_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR:  if (clr_q == AW'(ROWS - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept && exists && (operation == OP_READ || !pad_hit)) begin
					state_d = ST_RD;
				end
			end
			ST_RD:   state_d = ST_EXE;
			ST_EXE:  state_d = (op_q == OP_READ) ? ST_IDLE : ST_WR;
			ST_WR:   state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_t'(operation);
			addr_q <= addr_in;
			for (int l = 0; l < ACT_LANES; l++) grad_q[l] <= grad_in[l];
		end
	end

	// row store: one write and one registered read port
	logic [RW-1:0] mem [ROWS];
	logic [RW-1:0] rd_q, wr_data, sum_row;
	logic          mem_we;
	logic [AW-1:0] wr_addr;

	// write-back controls
	always_comb begin
		mem_we = 1'b0;
		wr_addr = addr_q;
		wr_data = '0;
		case (state_q)
			ST_CLR: begin
				mem_we = 1'b1;
				wr_addr = clr_q;
			end
			ST_EXE:  mem_we = (op_q == OP_READ);
			ST_WR: begin
				mem_we = 1'b1;
				wr_data = sum_row;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
		if (state_q == ST_RD) rd_q <= mem[addr_q];
	end

	// one adder per lane, all working on the same row chunk
	for (genvar l = 0; l < ACT_LANES; l++) begin : g_lane
		egsa_fp_add u_add (
			.clk (clk),
			.en  (state_q == ST_EXE),
			.a   (rd_q[l*FP_W +: FP_W]),
			.b   (grad_q[l]),
			.sum (sum_row[l*FP_W +: FP_W])
		);
	end

	// result register: drop on take, load on a read word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if ((accept && operation == OP_READ && !exists)
				|| (state_q == ST_EXE && op_q == OP_READ)) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && operation == OP_READ && !exists) begin
			row_valid_q <= 1'b0;
			for (int l = 0; l < FIELD_LANES; l++) sum_q[l] <= '0;
		end else if (state_q == ST_EXE && op_q == OP_READ) begin
			row_valid_q <= 1'b1;
			for (int l = 0; l < FIELD_LANES; l++) begin
				sum_q[l] <= (l < ACT_LANES) ? rd_q[(l % ACT_LANES)*FP_W +: FP_W] : '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign row_valid = row_valid_q;
	assign sum_lane_0 = sum_q[0];
	assign sum_lane_1 = sum_q[1];
	assign sum_lane_2 = sum_q[2];
	assign sum_lane_3 = sum_q[3];

`ifndef SYNTH
	a_clr_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |-> in_stall)
		else $error("word accepted during clearing pass");
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXE && op_q == OP_READ) |-> !out_valid_q)
		else $error("read result would overwrite a waiting result");
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RD || state_q == ST_IDLE))
		else $error("bad state after accept");
`endif

endmodule

// ===== design/egsa_fp_add.sv =====
module egsa_fp_add (
	input  logic                     clk,
	input  logic                     en,
	input  logic [egsa_pkg::FP_W-1:0] a,
	input  logic [egsa_pkg::FP_W-1:0] b,
	output logic [egsa_pkg::FP_W-1:0] sum
);
	import egsa_pkg::*;

	// stage 1: unpack, handle specials, align and add
	logic        sa, sb, a_nan, b_nan, a_inf, b_inf, swap;
	logic [7:0]  ea, eb, eab, ebb, ebig, esml;
	logic [23:0] ma, mb;
	logic [26:0] mbig, msml, msh, mask;
	logic [7:0]  diff;
	logic        sticky, sbig, sub;
	logic [27:0] res;
	logic        spec;
	logic [FP_W-1:0] spec_val;

	always_comb begin
		sa = a[31];
		sb = b[31];
		ea = a[30:23];
		eb = b[30:23];
		a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
		a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
		b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);
		spec = 1'b1;
		spec_val = '0;
		if (a_nan) begin
			spec_val = a | FP_QUIET_BIT;
		end else if (b_nan) begin
			spec_val = b | FP_QUIET_BIT;
		end else if (a_inf && b_inf && (sa != sb)) begin
			spec_val = FP_DEFAULT_NAN;
		end else if (a_inf) begin
			spec_val = a;
		end else if (b_inf) begin
			spec_val = b;
		end else begin
			spec = 1'b0;
		end
		ma = {ea != 8'd0, a[22:0]};
		mb = {eb != 8'd0, b[22:0]};
		eab = (ea == 8'd0) ? 8'd1 : ea;
		ebb = (eb == 8'd0) ? 8'd1 : eb;
		swap = b[30:0] > a[30:0];
		mbig = swap ? {mb, 3'b000} : {ma, 3'b000};
		msml = swap ? {ma, 3'b000} : {mb, 3'b000};
		ebig = swap ? ebb : eab;
		esml = swap ? eab : ebb;
		sbig = swap ? sb : sa;
		sub = sa ^ sb;
		diff = ebig - esml;
		if (diff >= 8'd27) begin
			mask = '0;
			msh = '0;
			sticky = |msml;
		end else begin
			mask = (27'd1 << diff[4:0]) - 27'd1;
			msh = msml >> diff[4:0];
			sticky = |(msml & mask);
		end
		msh[0] = msh[0] | sticky;
		res = sub ? ({1'b0, mbig} - {1'b0, msh}) : ({1'b0, mbig} + {1'b0, msh});
	end

	logic            sign_s1, sub_s1, spec_s1;
	logic [7:0]      exp_s1;
	logic [27:0]     res_s1;
	logic [FP_W-1:0] spec_s1_val;

	always_ff @(posedge clk) begin
		if (en) begin
			sign_s1 <= sbig;
			sub_s1 <= sub;
			spec_s1 <= spec;
			spec_s1_val <= spec_val;
			exp_s1 <= ebig;
			res_s1 <= res;
		end
	end

	// stage 2: normalize and round to nearest even
	logic [4:0]  lz, maxsh, sh;
	logic        found, up, sgn;
	logic [26:0] n;
	logic [9:0]  en_n, eout;
	logic [24:0] m25;

	always_comb begin
		lz = 5'd27;
		found = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (!found && res_s1[i]) begin
				lz = 5'(26 - i);
				found = 1'b1;
			end
		end
		maxsh = (exp_s1 > 8'd27) ? 5'd27 : 5'(exp_s1 - 8'd1);
		sh = (lz < maxsh) ? lz : maxsh;
		if (res_s1[27]) begin
			n = {res_s1[27:2], res_s1[1] | res_s1[0]};
			en_n = {2'b00, exp_s1} + 10'd1;
		end else begin
			n = res_s1[26:0] << sh;
			en_n = {2'b00, exp_s1} - {5'd0, sh};
		end
		up = n[2] && ((|n[1:0]) || n[3]);
		m25 = {1'b0, n[26:3]} + {24'd0, up};
		if (m25[24]) begin
			eout = en_n + 10'd1;
		end else if (m25[23]) begin
			eout = en_n;
		end else begin
			eout = '0;
		end
		sgn = (res_s1 == 28'd0 && sub_s1) ? 1'b0 : sign_s1;
		if (spec_s1) begin
			sum = spec_s1_val;
		end else if (eout >= 10'd255) begin
			sum = {sgn, 8'hFF, 23'd0};
		end else if (m25[24]) begin
			sum = {sgn, eout[7:0], m25[23:1]};
		end else begin
			sum = {sgn, eout[7:0], m25[22:0]};
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import egsa_pkg::*;

	localparam int VOCAB_MAX  = 1024;
	localparam int CHUNK_MAX  = 16;
	localparam int SETTLE     = 10;
	localparam int CYCLE_CAP  = 800000;

	typedef struct packed {
		logic [31:0] s0;
		logic [31:0] s1;
		logic [31:0] s2;
		logic [31:0] s3;
		logic        rv;
	} chunk_sum_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [15:0] token;
	logic [3:0]  chunk_index;
	logic [31:0] grad_lane_0;
	logic [31:0] grad_lane_1;
	logic [31:0] grad_lane_2;
	logic [31:0] grad_lane_3;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] sum_lane_0;
	logic [31:0] sum_lane_1;
	logic [31:0] sum_lane_2;
	logic [31:0] sum_lane_3;
	logic        row_valid;

	// Shadow copy of the table and registers, updated as words are accepted
	logic [31:0] shadow_sums [0:VOCAB_MAX*CHUNK_MAX*4-1];
	logic [10:0] vocab_r;
	logic [4:0]  chunks_r;
	logic [10:0] pad_r;

	chunk_sum_t pending_sums [$];
	int         mismatches = 0;
	int         cycles = 0;
	bit         calm;
	int         stall_run = 0;

	embedding_grad_scatter_add_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.token       (token),
		.chunk_index (chunk_index),
		.grad_lane_0 (grad_lane_0),
		.grad_lane_1 (grad_lane_1),
		.grad_lane_2 (grad_lane_2),
		.grad_lane_3 (grad_lane_3),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sum_lane_0  (sum_lane_0),
		.sum_lane_1  (sum_lane_1),
		.sum_lane_2  (sum_lane_2),
		.sum_lane_3  (sum_lane_3),
		.row_valid   (row_valid)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Single-precision add, round to nearest even, subnormals kept.
	// NaN operands come back quieted, the first one winning.
	function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] x;
		logic [31:0] y;
		logic        sr;
		logic        up;
		logic [27:0] ma;
		logic [27:0] mb;
		logic [27:0] m;
		logic [27:0] t;
		int          ex;
		int          ey;
		int          d;
		if (a[30:23] == 8'hFF && a[22:0] != 0) return a | FP_QUIET_BIT;
		if (b[30:23] == 8'hFF && b[22:0] != 0) return b | FP_QUIET_BIT;
		if (a[30:23] == 8'hFF) begin
			if (b[30:23] == 8'hFF && a[31] != b[31]) return FP_DEFAULT_NAN;
			return a;
		end
		if (b[30:23] == 8'hFF) return b;
		// order by magnitude so x is the larger operand
		if (b[30:0] > a[30:0]) begin
			x = b;
			y = a;
		end else begin
			x = a;
			y = b;
		end
		ex = (x[30:23] == 0) ? 1 : x[30:23];
		ey = (y[30:23] == 0) ? 1 : y[30:23];
		ma = {1'b0, x[30:23] != 0, x[22:0], 3'b000};
		mb = {1'b0, y[30:23] != 0, y[22:0], 3'b000};
		d = ex - ey;
		if (d >= 27) begin
			mb = (mb != 0) ? 28'd1 : 28'd0;
		end else if (d > 0) begin
			t = mb & ((28'd1 << d) - 28'd1);
			mb = (mb >> d) | (t != 0);
		end
		sr = x[31];
		if (x[31] == y[31]) begin
			m = ma + mb;
			if (m[27]) begin
				m = (m >> 1) | m[0];
				ex++;
			end
		end else begin
			m = ma - mb;
			// exact cancellation gives +0
			if (m == 0) return 32'h0;
			while (!m[26] && ex > 1) begin
				m = m << 1;
				ex--;
			end
		end
		up = m[2] && (m[1] || m[0] || m[3]);
		m = (m >> 3) + up;
		if (m[24]) begin
			m = m >> 1;
			ex++;
		end
		if (ex >= 255) return {sr, 8'hFF, 23'h0};
		return {sr, m[23] ? ex[7:0] : 8'h00, m[22:0]};
	endfunction

	// Apply one accepted word to the shadow table; reads queue their sums
	task automatic apply_word(input logic op, input logic [15:0] tok, input logic [3:0] ch,
			input logic [31:0] g0, input logic [31:0] g1,
			input logic [31:0] g2, input logic [31:0] g3);
		int         vlim;
		int         clim;
		int         base;
		bit         live;
		chunk_sum_t r;
		vlim = (vocab_r > VOCAB_MAX) ? VOCAB_MAX : vocab_r;
		clim = (chunks_r > CHUNK_MAX) ? CHUNK_MAX : chunks_r;
		live = (tok < vlim) && (ch < clim);
		base = (tok * CHUNK_MAX + ch) * 4;
		if (op == OP_ACC) begin
			// padding matches only when nonnegative
			if (live && !(pad_r[10] == 1'b0 && tok == pad_r)) begin
				shadow_sums[base]     = fp32_add(shadow_sums[base], g0);
				shadow_sums[base + 1] = fp32_add(shadow_sums[base + 1], g1);
				shadow_sums[base + 2] = fp32_add(shadow_sums[base + 2], g2);
				shadow_sums[base + 3] = fp32_add(shadow_sums[base + 3], g3);
			end
		end else begin
			r = '0;
			r.rv = live;
			if (live) begin
				r.s0 = shadow_sums[base];
				r.s1 = shadow_sums[base + 1];
				r.s2 = shadow_sums[base + 2];
				r.s3 = shadow_sums[base + 3];
				for (int l = 0; l < 4; l++) shadow_sums[base + l] = 32'h0;
			end
			pending_sums.push_back(r);
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Drive one word, hold it until accepted, then idle for a random gap, which may be zero
	task automatic send_word(input logic op, input logic [15:0] tok, input logic [3:0] ch,
			input logic [31:0] g0, input logic [31:0] g1,
			input logic [31:0] g2, input logic [31:0] g3);
		bit taken;
		int gap;
		in_valid    <= 1'b1;
		operation   <= op;
		token       <= tok;
		chunk_index <= ch;
		grad_lane_0 <= g0;
		grad_lane_1 <= g1;
		grad_lane_2 <= g2;
		grad_lane_3 <= g3;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		apply_word(op, tok, ch, g0, g1, g2, g3);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		// accumulates produce nothing, so let the pipeline empty too
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_AW'(idx) << 2;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			CFG_VOCAB: begin
				vocab_r = value[10:0];
			end
			CFG_CHUNKS: begin
				chunks_r = value[4:0];
			end
			default: begin
				pad_r = value[10:0];
			end
		endcase
	endtask

	task automatic set_config(input logic [10:0] v, input logic [4:0] c, input logic [10:0] p);
		drain_results();
		cfg_write(CFG_VOCAB, 32'(v));
		cfg_write(CFG_CHUNKS, 32'(c));
		cfg_write(CFG_PADDING, 32'(p));
	endtask

	// Mostly ordinary magnitudes so sums stay meaningful, with raw words and specials
	function automatic logic [31:0] pick_grad();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return {1'($urandom), 8'($urandom_range(115, 135)), 23'($urandom)};
		if (r < 85) return $urandom;
		case ($urandom_range(0, 5))
			0: return {1'($urandom), 31'h0};
			1: return {1'($urandom), 8'h00, 23'($urandom)};
			2: return {1'($urandom), 8'hFF, 23'h0};
			3: return {1'($urandom), 8'hFF, 23'($urandom) | 23'h1};
			4: return {1'($urandom), 8'hFE, 23'h7FFFFF};
			default: return {1'($urandom), 8'h01, 23'h0};
		endcase
	endfunction

	function automatic logic [15:0] pick_token();
		int r;
		int vlim;
		vlim = (vocab_r > VOCAB_MAX) ? VOCAB_MAX : vocab_r;
		r = $urandom_range(0, 99);
		if (r < 65) return 16'($urandom_range(0, 7));
		if (r < 82) return 16'($urandom_range(vlim < 2 ? 0 : vlim - 2, vlim + 1));
		if (r < 90 && !pad_r[10]) return 16'(pad_r);
		return 16'($urandom);
	endfunction

	task automatic random_words(input int count);
		logic op;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(0, 99) < 30) ? OP_READ : OP_ACC;
			send_word(op, pick_token(), 4'($urandom),
				pick_grad(), pick_grad(), pick_grad(), pick_grad());
		end
	endtask

	task automatic test_directed();
		calm = 1'b0;
		// ordinary sums, then read twice to see the clear
		send_word(OP_ACC, 16'd0, 4'd0, 32'h3F800000, 32'h40000000, 32'h80000000, 32'h00000001);
		send_word(OP_ACC, 16'd0, 4'd0, 32'h3F800000, 32'hC0000000, 32'h00000000, 32'h80000001);
		send_word(OP_READ, 16'd0, 4'd0, '0, '0, '0, '0);
		send_word(OP_READ, 16'd0, 4'd0, '0, '0, '0, '0);
		// infinities cancel to NaN, NaN propagates, max overflows
		send_word(OP_ACC, 16'd1, 4'd15, 32'h7F800000, 32'h7FC00001, 32'h7F7FFFFF, 32'hFF800000);
		send_word(OP_ACC, 16'd1, 4'd15, 32'hFF800000, 32'h3F800000, 32'h7F7FFFFF, 32'h7FA00000);
		send_word(OP_READ, 16'd1, 4'd15, '0, '0, '0, '0);
		// top row, dropped rows, invalid reads
		send_word(OP_ACC, 16'd1023, 4'd15, 32'hFFFFFFFF, 32'h00800000, 32'h807FFFFF, 32'h3F7FFFFF);
		send_word(OP_READ, 16'd1023, 4'd15, '0, '0, '0, '0);
		send_word(OP_ACC, 16'd1024, 4'd3, 32'h3F800000, 32'h3F800000, 32'h3F800000, 32'h3F800000);
		send_word(OP_READ, 16'd1024, 4'd3, '0, '0, '0, '0);
		send_word(OP_READ, 16'hFFFF, 4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		// back-to-back accumulates on one row with no gaps, then a read
		calm = 1'b1;
		for (int i = 0; i < 4; i++)
			send_word(OP_ACC, 16'd2, 4'd7, 32'h3F800000, 32'h3E800000, 32'h33800000, 32'hBF800000);
		send_word(OP_READ, 16'd2, 4'd7, '0, '0, '0, '0);
		calm = 1'b0;
		// padding row stays zero but reads valid
		set_config(11'd1024, 5'd16, 11'd5);
		send_word(OP_ACC, 16'd5, 4'd0, 32'h3F800000, 32'h3F800000, 32'h3F800000, 32'h3F800000);
		send_word(OP_READ, 16'd5, 4'd0, '0, '0, '0, '0);
		// width limit drops higher chunks
		set_config(11'd1024, 5'd4, 11'h7FF);
		send_word(OP_ACC, 16'd3, 4'd4, 32'h3F800000, 32'h3F800000, 32'h3F800000, 32'h3F800000);
		send_word(OP_READ, 16'd3, 4'd4, '0, '0, '0, '0);
		send_word(OP_READ, 16'd3, 4'd3, '0, '0, '0, '0);
	endtask

	task automatic test_config_sweep();
		// zero rows and chunks: everything dropped and invalid
		set_config(11'd0, 5'd0, 11'h7FF);
		random_words(60);
		set_config(11'd1, 5'd1, 11'd0);
		random_words(80);
		// above the limits acts as the limits
		set_config(11'h7FF, 5'h1F, 11'd1023);
		random_words(100);
		set_config(11'd5, 5'd3, 11'd2);
		random_words(100);
		set_config(11'($urandom_range(1, 2047)), 5'($urandom_range(1, 31)), 11'($urandom));
		random_words(100);
	endtask

	task automatic test_random();
		set_config(11'd8, 5'd16, 11'h400);
		random_words(200);
		// hold the sender until every read has returned
		drain_results();
		calm = 1'b1;
		random_words(150);
		calm = 1'b0;
		set_config(11'd1024, 5'd16, 11'h7FF);
		random_words(250);
	endtask

	// Receiver stalls: short bursts mostly, some long, none begun while calm
	always @(posedge clk) begin
		int roll;
		roll = $urandom_range(0, 99);
		if (stall_run > 0) begin
			stall_run <= stall_run - 1;
			out_stall <= 1'b1;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else if (roll < 70) begin
			out_stall <= 1'b0;
		end else if (roll < 97) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b1;
			stall_run <= $urandom_range(10, 30);
		end
	end

	// Compare each taken result word with the oldest pending sums
	always @(negedge clk) begin
		chunk_sum_t got;
		chunk_sum_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{sum_lane_0, sum_lane_1, sum_lane_2, sum_lane_3, row_valid};
			if (pending_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", got);
			end else begin
				want = pending_sums.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h %h %h %h rv %b, got %h %h %h %h rv %b",
							want.s0, want.s1, want.s2, want.s3, want.rv,
							got.s0, got.s1, got.s2, got.s3, got.rv);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("[embedding_grad_scatter_add_core] ERROR");
			$finish;
		end
	end

	initial begin
		calm       = 1'b0;
		vocab_r    = 11'd1024;
		chunks_r   = 5'd16;
		pad_r      = 11'h7FF;
		for (int i = 0; i < VOCAB_MAX * CHUNK_MAX * 4; i++) shadow_sums[i] = 32'h0;
		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		in_valid    <= 1'b0;
		operation   <= OP_ACC;
		token       <= '0;
		chunk_index <= '0;
		grad_lane_0 <= '0;
		grad_lane_1 <= '0;
		grad_lane_2 <= '0;
		grad_lane_3 <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_random();
		drain_results();
		if (mismatches == 0 && pending_sums.size() == 0) begin
			$display("[embedding_grad_scatter_add_core] OK");
		end else begin
			$display("[embedding_grad_scatter_add_core] ERROR");
		end
		$finish;
	end

endmodule
